### design/aota_pkg.sv
// ----------------------------------------------------------------------------
// ASID owner table allocator: shared package
// Table geometry, payload structs, result codes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package aota_pkg;

  localparam int ENTRIES    = 256;
  localparam int COUNT_BITS = 14;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int ASID_W     = 8;
  localparam int TAG_W      = 18;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONE_IDLE    = 2'd1,
    ST_SATURATED    = 2'd2,
    ST_IDLE_RELEASE = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic [TAG_W-1:0]   owner_tag;
    logic [ASID_W-1:0]  held_asid;
  } in_item_t;

  typedef struct packed {
    logic [ASID_W-1:0]  granted_asid;
    logic               flush_needed;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_SCAN_RD,
    S_SCAN_EVAL
  } state_t;

  typedef enum logic [0:0] {
    RD_HELD,
    RD_CAND
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INC,
    WR_DEC,
    WR_STEAL
  } wr_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_HELD_OK,
    RES_HELD_SAT,
    RES_IDLE_REL,
    RES_NONE_IDLE,
    RES_STEAL
  } res_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_init;
    logic    scan_adv;
    wr_op_t  wr_op;
    res_op_t res_op;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic tag_zero;
    logic out_of_table;
    logic hit;
    logic cnt_zero;
    logic cnt_sat;
    logic scan_last;
  } dp_stat_t;

endpackage

### design/aota_ctrl.sv
// ----------------------------------------------------------------------------
// ASID owner table allocator: controller
// Sequences lookup of the held entry, the hit/release decision and the
// round-robin steal scan; drives the datapath through a command struct.
// ----------------------------------------------------------------------------
module aota_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  aota_pkg::dp_stat_t stat,
  output aota_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import aota_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.is_release && !stat.tag_zero && !stat.hit) state_nxt = S_SCAN_RD;
        else state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_EVAL;
      end
      S_SCAN_EVAL: begin
        if (stat.cnt_zero || stat.scan_last) state_nxt = S_IDLE;
        else state_nxt = S_SCAN_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_HELD;
    cmd.wr_op     = WR_NONE;
    cmd.res_op    = RES_NONE;
    busy          = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_LOOK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HELD;
      end
      S_EVAL: begin
        priority if (stat.is_release) begin
          if (stat.out_of_table || stat.cnt_zero) begin
            cmd.res_op = RES_IDLE_REL;
          end else begin
            cmd.wr_op  = WR_DEC;
            cmd.res_op = RES_HELD_OK;
          end
        end else if (stat.tag_zero) begin
          cmd.res_op = RES_NONE_IDLE;
        end else if (stat.hit) begin
          if (stat.cnt_sat) begin
            cmd.res_op = RES_HELD_SAT;
          end else begin
            cmd.wr_op  = WR_INC;
            cmd.res_op = RES_HELD_OK;
          end
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CAND;
      end
      S_SCAN_EVAL: begin
        priority if (stat.cnt_zero) begin
          cmd.wr_op  = WR_STEAL;
          cmd.res_op = RES_STEAL;
        end else if (stat.scan_last) begin
          cmd.res_op = RES_NONE_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      default: begin
        cmd.res_op = RES_NONE;
      end
    endcase
  end

endmodule

### design/aota_dp.sv
// ----------------------------------------------------------------------------
// ASID owner table allocator: datapath
// Entry memory (tag and running count), per-entry valid bits, the limit
// register, the round-robin pointer with its scan counter, and the result
// register.
// ----------------------------------------------------------------------------
module aota_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aota_pkg::in_item_t            in_item,
  input  logic                          cfg_we,
  input  logic [aota_pkg::ASID_W-1:0]   cfg_wdata,
  input  aota_pkg::ctl_cmd_t            cmd,
  output aota_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output aota_pkg::out_item_t           out_item
);
  import aota_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  cmd_t               cmd_r;
  logic [TAG_W-1:0]   tag_r;
  logic [ASID_W-1:0]  held_r;
  logic [ASID_W-1:0]  highest_r;
  logic [IDX_W-1:0]   next_r;
  logic [IDX_W-1:0]   cand_r;
  logic [IDX_W-1:0]   n_r;
  entry_t             rd_q_r;
  logic               rd_vld_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [IDX_W-1:0]      held_idx;
  logic [IDX_W-1:0]      lim;
  logic [IDX_W-1:0]      after;
  logic [IDX_W-1:0]      rd_addr;
  logic [TAG_W-1:0]      rd_tag;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;

  assign held_idx = held_r[IDX_W-1:0];
  assign lim      = ({1'b0, highest_r} >= (ASID_W+1)'(ENTRIES)) ? IDX_W'(ENTRIES - 1)
                                                                  : highest_r[IDX_W-1:0];
  assign after    = (cand_r == lim) ? '0 : cand_r + IDX_W'(1);
  assign rd_addr  = (cmd.rd_sel == RD_CAND) ? cand_r : held_idx;

  // A never-written entry reads as free.
  assign rd_tag = rd_vld_r ? rd_q_r.tag : '0;
  assign rd_cnt = rd_vld_r ? rd_q_r.cnt : '0;

  always_comb begin
    stat.is_release   = (cmd_r == CMD_RELEASE);
    stat.tag_zero     = (tag_r == '0);
    stat.out_of_table = ({1'b0, held_r} >= (ASID_W+1)'(ENTRIES));
    stat.hit          = !stat.out_of_table && (rd_tag == tag_r);
    stat.cnt_zero     = (rd_cnt == '0);
    stat.cnt_sat      = (rd_cnt == COUNT_MAX);
    stat.scan_last    = (n_r == lim);
  end

  always_comb begin
    wr_en   = (cmd.wr_op != WR_NONE);
    wr_addr = held_idx;
    wr_data = rd_q_r;
    unique case (cmd.wr_op)
      WR_INC: begin
        wr_data.tag = rd_tag;
        wr_data.cnt = rd_cnt + COUNT_BITS'(1);
      end
      WR_DEC: begin
        wr_data.tag = rd_tag;
        wr_data.cnt = rd_cnt - COUNT_BITS'(1);
      end
      WR_STEAL: begin
        wr_addr     = cand_r;
        wr_data.tag = tag_r;
        wr_data.cnt = COUNT_BITS'(1);
      end
      default: begin
        wr_data = rd_q_r;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  // Control state: valid bits, pointer, limit, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      highest_r   <= ASID_W'(254);
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= valid_r[rd_addr];
      if (cfg_we) highest_r <= cfg_wdata;
      if (cmd.wr_op == WR_STEAL) next_r <= after;
      out_valid_r <= (cmd.res_op != RES_NONE);
    end
  end

  // Transaction and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_item.command;
      tag_r  <= in_item.owner_tag;
      held_r <= in_item.held_asid;
    end
    if (cmd.scan_init) begin
      cand_r <= (next_r > lim) ? '0 : next_r;
      n_r    <= '0;
    end else if (cmd.scan_adv) begin
      cand_r <= after;
      n_r    <= n_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_op)
      RES_HELD_OK: begin
        out_item_r <= '{granted_asid: held_r, flush_needed: 1'b0, status: ST_OK};
      end
      RES_HELD_SAT: begin
        out_item_r <= '{granted_asid: held_r, flush_needed: 1'b0, status: ST_SATURATED};
      end
      RES_IDLE_REL: begin
        out_item_r <= '{granted_asid: held_r, flush_needed: 1'b0, status: ST_IDLE_RELEASE};
      end
      RES_NONE_IDLE: begin
        out_item_r <= '{granted_asid: '0, flush_needed: 1'b0, status: ST_NONE_IDLE};
      end
      RES_STEAL: begin
        out_item_r <= '{granted_asid: ASID_W'(cand_r), flush_needed: 1'b1, status: ST_OK};
      end
      default: begin
        out_item_r <= out_item_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/asid_owner_table_allocator_top.sv
// ----------------------------------------------------------------------------
// ASID owner table allocator: top level
// Hands out address-space identifiers to owners, counts users per entry and
// steals an idle entry round-robin when an owner's old identifier is gone.
//
// Usage:
//   Input: present in_item and raise start; the transaction is taken on a
//   clock edge with start high and busy low. command selects acquire or
//   release.
//   Result: exactly one result per transaction, on out_item for one cycle
//   with out_valid high. The receiver cannot stall; it must take it then.
//   Config: cfg_we/cfg_wdata write highest_asid, the wrap point of the
//   round-robin pointer. Write it only while the block is idle.
//   Sequence: hit, release or refused acquire: a read of the held entry,
//   then its check; the result is registered. A steal adds one memory
//   read and one check per entry examined, over up to limit+1 entries;
//   the single-port entry memory read sets that pace. busy stays high
//   until the result is registered; no new transaction is taken before.
//   Reset: all entries read as free with zero count, the pointer is zero,
//   highest_asid is 254; no clearing pass is needed.
// ----------------------------------------------------------------------------
module asid_owner_table_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  aota_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output aota_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [aota_pkg::ASID_W-1:0]  cfg_wdata
);
  import aota_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  aota_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  aota_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### design/aota_chk.sv
// ----------------------------------------------------------------------------
// ASID owner table allocator: port checker
// Temporal checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module aota_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input aota_pkg::out_item_t out_item
);
  import aota_pkg::*;

  // Accepted transaction holds busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  // No result the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result one cycle after accept");

  // Result strobe is a single pulse
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // Flush only with a good status, refusal carries no identifier
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!out_item.flush_needed || out_item.status == ST_OK) &&
                   (out_item.status != ST_NONE_IDLE ||
                    (out_item.granted_asid == '0 && !out_item.flush_needed))))
    else $error("inconsistent result fields");

endmodule

bind asid_owner_table_allocator_top aota_chk u_aota_chk (.*);

### dv/aota_grant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASID owner table allocator: result checker
// Mirrors the owner table, user counts, round-robin pointer and wrap limit.
// It predicts the grant for every accepted transaction and compares each
// strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module aota_grant_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  aota_pkg::in_item_t            in_item,
  input  logic                          out_valid,
  input  aota_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [aota_pkg::ASID_W-1:0]   cfg_wdata,
  output int                            mismatch_count,
  output int                            grants_pending
);
  import aota_pkg::*;

  logic [TAG_W-1:0]      tag_mirror   [ENTRIES];
  logic [COUNT_BITS-1:0] count_mirror [ENTRIES];
  logic [ASID_W-1:0]     rr_pointer;
  logic [ASID_W-1:0]     wrap_limit;
  out_item_t             expected_grants [$];
  out_item_t             want;

  function automatic out_item_t predict_grant(in_item_t it);
    out_item_t r;
    int        lim;
    int        cand;
    int        nxt;
    int        n;
    r.granted_asid = '0;
    r.flush_needed = 1'b0;
    r.status       = ST_NONE_IDLE;
    if (it.command == CMD_RELEASE) begin
      // the tag is ignored; a count that drops to zero keeps its tag
      r.granted_asid = it.held_asid;
      if (int'(it.held_asid) >= ENTRIES || count_mirror[it.held_asid] == '0) begin
        r.status = ST_IDLE_RELEASE;
      end else begin
        count_mirror[it.held_asid] = count_mirror[it.held_asid] - COUNT_BITS'(1);
        r.status = ST_OK;
      end
      return r;
    end
    // a zero tag is refused like a full table
    if (it.owner_tag == '0) begin
      return r;
    end
    if (int'(it.held_asid) < ENTRIES && tag_mirror[it.held_asid] == it.owner_tag) begin
      r.granted_asid = it.held_asid;
      if (count_mirror[it.held_asid] == COUNT_MAX) begin
        r.status = ST_SATURATED;
      end else begin
        count_mirror[it.held_asid] = count_mirror[it.held_asid] + COUNT_BITS'(1);
        r.status = ST_OK;
      end
      return r;
    end
    // steal: scan from the pointer, restart at zero if it sits above the limit
    lim  = (int'(wrap_limit) >= ENTRIES) ? ENTRIES - 1 : int'(wrap_limit);
    cand = (int'(rr_pointer) > lim) ? 0 : int'(rr_pointer);
    for (n = 0; n <= lim; n++) begin
      nxt = (cand == lim) ? 0 : cand + 1;
      if (count_mirror[cand[IDX_W-1:0]] == '0) begin
        tag_mirror[cand[IDX_W-1:0]]   = it.owner_tag;
        count_mirror[cand[IDX_W-1:0]] = COUNT_BITS'(1);
        rr_pointer                    = nxt[ASID_W-1:0];
        r.granted_asid                = cand[ASID_W-1:0];
        r.flush_needed                = 1'b1;
        r.status                      = ST_OK;
        return r;
      end
      cand = nxt;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tag_mirror[i]) begin
        tag_mirror[i]   = '0;
        count_mirror[i] = '0;
      end
      rr_pointer     = '0;
      wrap_limit     = 8'd254;
      mismatch_count = 0;
      expected_grants.delete();
      grants_pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual asid %0d flush %0d status %0d",
                   $time, out_item.granted_asid, out_item.flush_needed, out_item.status);
          mismatch_count++;
        end else begin
          want = expected_grants.pop_front();
          if (out_item.granted_asid !== want.granted_asid) begin
            $display("%0t: granted_asid expected %0d actual %0d",
                     $time, want.granted_asid, out_item.granted_asid);
            mismatch_count++;
          end
          if (out_item.flush_needed !== want.flush_needed) begin
            $display("%0t: flush_needed expected %0d actual %0d",
                     $time, want.flush_needed, out_item.flush_needed);
            mismatch_count++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_item.status);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        wrap_limit = cfg_wdata;
      end
      if (start && !busy) begin
        expected_grants.push_back(predict_grant(in_item));
      end
      grants_pending <= expected_grants.size();
    end
  end

endmodule

### dv/asid_owner_table_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASID owner table allocator: testbench top
// Drives directed corner transactions, a back-to-back hit run and random
// process traffic under several wrap limits; the checker beside the block
// predicts every grant and this module reports the verdict.
// ----------------------------------------------------------------------------
module asid_owner_table_allocator_top_tb;
  import aota_pkg::*;

  localparam int PROCS        = 12;
  localparam int PHASE_ITEMS  = 200;
  localparam int CALM_ITEMS   = 150;
  localparam int HIT_RUN      = 8;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam logic [TAG_W-1:0] TAG_ALL_ONES = {TAG_W{1'b1}};

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we;
  logic [ASID_W-1:0]   cfg_wdata;

  int                  mismatch_count;
  int                  grants_pending;
  int                  cycle_count = 0;
  bit                  gaps_on;

  // process pool used to build well-formed acquire/release traffic
  logic [TAG_W-1:0]    proc_tag   [PROCS];
  logic [ASID_W-1:0]   proc_asid  [PROCS];
  int                  proc_holds [PROCS];
  int                  issued_proc [$];
  int                  code;
  int                  pidx;

  asid_owner_table_allocator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  aota_grant_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .grants_pending (grants_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // learn which identifier each process now holds
  always @(posedge clk) begin
    if (rst_n && out_valid && issued_proc.size() != 0) begin
      code = issued_proc.pop_front();
      if (code >= 0 && out_item.status == ST_OK) begin
        pidx = code / 2;
        if (code % 2 == 1) begin
          if (proc_holds[pidx] > 0) begin
            proc_holds[pidx] <= proc_holds[pidx] - 1;
          end
        end else if (out_item.flush_needed) begin
          proc_asid[pidx]  <= out_item.granted_asid;
          proc_holds[pidx] <= 1;
        end else begin
          proc_holds[pidx] <= proc_holds[pidx] + 1;
        end
      end
    end
  end

  function automatic in_item_t make_item(cmd_t cmd, logic [TAG_W-1:0] tag,
                                         logic [ASID_W-1:0] asid);
    in_item_t it;
    it.command   = cmd;
    it.owner_tag = tag;
    it.held_asid = asid;
    return it;
  endfunction

  // hold start until the transaction is taken; who = 2*process+command, or -1
  task automatic issue(in_item_t it, int who);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    issued_proc.push_back(who);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (grants_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [ASID_W-1:0] lim);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_step();
    in_item_t it;
    int       p;
    int       who;
    p = $urandom_range(0, PROCS - 1);
    if ($urandom_range(0, 9) == 0) begin
      it.command   = cmd_t'($urandom_range(0, 1));
      it.owner_tag = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      it.held_asid = ASID_W'($urandom_range(0, (1 << ASID_W) - 1));
      who = -1;
    end else if (proc_holds[p] > 0 && $urandom_range(0, 1) == 0) begin
      it.command   = CMD_RELEASE;
      it.owner_tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, (1 << TAG_W) - 1))
                                                 : proc_tag[p];
      it.held_asid = proc_asid[p];
      who = 2 * p + 1;
    end else begin
      it.command   = CMD_ACQUIRE;
      it.owner_tag = proc_tag[p];
      // now and then a stale identifier forces a steal
      it.held_asid = ($urandom_range(0, 15) == 0) ? ASID_W'($urandom_range(0, (1 << ASID_W) - 1))
                                                  : proc_asid[p];
      who = 2 * p;
    end
    issue(it, who);
  endtask

  initial begin
    logic [ASID_W-1:0] phase_limit [6];
    int                n;
    int                ph;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    gaps_on   = 1'b1;
    foreach (proc_tag[i]) begin
      proc_tag[i]   = TAG_W'($urandom_range(1, (1 << TAG_W) - 1));
      proc_asid[i]  = ASID_W'($urandom_range(0, (1 << ASID_W) - 1));
      proc_holds[i] = 0;
    end
    proc_tag[0] = TAG_ALL_ONES;
    proc_tag[1] = 18'd1;
    phase_limit[0] = 8'd255;
    phase_limit[1] = 8'd7;
    phase_limit[2] = 8'd0;
    phase_limit[3] = 8'd2;
    phase_limit[4] = ASID_W'($urandom_range(0, 255));
    phase_limit[5] = 8'd254;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner transactions at the reset limit
    issue(make_item(CMD_RELEASE, 18'h15555, 8'd0), -1);
    issue(make_item(CMD_ACQUIRE, 18'd0, 8'd5), -1);
    issue(make_item(CMD_ACQUIRE, TAG_ALL_ONES, 8'd255), -1);
    issue(make_item(CMD_ACQUIRE, TAG_ALL_ONES, 8'd0), -1);
    issue(make_item(CMD_RELEASE, 18'd1, 8'd0), -1);
    issue(make_item(CMD_RELEASE, TAG_ALL_ONES, 8'd255), -1);
    issue(make_item(CMD_ACQUIRE, 18'd1, 8'd0), -1);
    issue(make_item(CMD_RELEASE, TAG_ALL_ONES, 8'd1), -1);
    issue(make_item(CMD_ACQUIRE, 18'd1, 8'd1), -1);

    // pointer above the limit, and a table with no idle entry
    write_limit(8'd0);
    issue(make_item(CMD_ACQUIRE, 18'd2, 8'd9), -1);
    issue(make_item(CMD_RELEASE, 18'd2, 8'd0), -1);
    issue(make_item(CMD_ACQUIRE, 18'd2, 8'd9), -1);

    write_limit(8'd3);
    issue(make_item(CMD_ACQUIRE, 18'd5, 8'd200), -1);
    issue(make_item(CMD_ACQUIRE, 18'd6, 8'd201), -1);
    issue(make_item(CMD_ACQUIRE, 18'd7, 8'd0), -1);
    issue(make_item(CMD_RELEASE, 18'd0, 8'd2), -1);

    // stack acquires on identifier 3 back to back, then release once and acquire again
    gaps_on = 1'b0;
    for (n = 0; n < HIT_RUN; n++) begin
      issue(make_item(CMD_ACQUIRE, 18'd6, 8'd3), -1);
    end
    issue(make_item(CMD_RELEASE, 18'd6, 8'd3), -1);
    issue(make_item(CMD_ACQUIRE, 18'd6, 8'd3), -1);
    gaps_on = 1'b1;

    for (ph = 0; ph < 6; ph++) begin
      write_limit(phase_limit[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n >= PHASE_ITEMS - CALM_ITEMS) begin
          gaps_on = 1'b0;
        end
        random_step();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
design/aota_pkg.sv
design/aota_ctrl.sv
design/aota_dp.sv
design/asid_owner_table_allocator_top.sv
design/aota_chk.sv
dv/aota_grant_checker.sv
dv/asid_owner_table_allocator_top_tb.sv
